// ===== hdl/bpa_pkg.sv =====
// shared types, constants and helpers for the buddy page allocator
package bpa_pkg;

	localparam int TOTAL_PAGES = 1024;
	localparam int PAGE_W      = $clog2(TOTAL_PAGES);
	localparam int CNT_W       = PAGE_W + 1;
	localparam int NODE_COUNT  = 2 * TOTAL_PAGES - 1;
	localparam int NODE_W      = $clog2(NODE_COUNT);

	typedef enum logic [1:0] {
		KIND_ALLOC   = 2'd0,
		KIND_FREE    = 2'd1,
		KIND_QUERY   = 2'd2,
		KIND_REBUILD = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK         = 2'd0,
		ST_NO_SPACE   = 2'd1,
		ST_BAD_OFFSET = 2'd2,
		ST_NOT_ALLOC  = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_INIT,
		S_A_ROOT,
		S_A_CHK,
		S_A_RD,
		S_A_DESC,
		S_MARK,
		S_F_RD,
		S_F_CHK,
		S_F_WR,
		S_U_L,
		S_U_R,
		S_U_W,
		S_DONE
	} state_t;

	typedef enum logic [4:0] {
		OP_NONE,
		OP_LOAD,
		OP_INIT,
		OP_ROOT_RD,
		OP_NOSPACE,
		OP_CHILD_RD,
		OP_DESC,
		OP_MARK,
		OP_NODE_RD,
		OP_CLIMB,
		OP_NOTALLOC,
		OP_FOUND,
		OP_RELEASE,
		OP_UP_LEFT,
		OP_UP_RIGHT,
		OP_UP_WRITE,
		OP_PUBLISH
	} dp_op_t;

	typedef struct packed {
		kind_t in_kind;
		logic  in_bad;
		logic  no_space;
		logic  want_hit;
		logic  next_hit;
		logic  idx_zero;
		logic  node_zero;
		logic  init_last;
		logic  is_free;
	} dp_stat_t;

	// round up to a power of two, zero taken as one
	function automatic logic [CNT_W-1:0] round_pow2(input logic [CNT_W-1:0] n);
		logic [CNT_W-1:0] m;
		logic [CNT_W-1:0] p;
		m = n - CNT_W'(1);
		p = CNT_W'(1);
		if (n > CNT_W'(1)) begin
			for (int i = 0; i < CNT_W; i++) begin
				if (m[i]) begin
					p = CNT_W'(1) << (i + 1);
				end
			end
		end
		return p;
	endfunction

endpackage

// ===== hdl/bpa_cmd_if.sv =====
// request channel of the buddy page allocator
interface bpa_cmd_if
	import bpa_pkg::*;
();
	logic              valid;
	logic              ready;
	logic [1:0]        kind;
	logic [CNT_W-1:0]  request_pages;
	logic [PAGE_W-1:0] page_offset;

	modport source (output valid, kind, request_pages, page_offset, input ready);
	modport sink (input valid, kind, request_pages, page_offset, output ready);
endinterface

// ===== hdl/bpa_rsp_if.sv =====
// response channel of the buddy page allocator
interface bpa_rsp_if
	import bpa_pkg::*;
();
	logic              valid;
	logic              ready;
	logic [1:0]        status;
	logic [PAGE_W-1:0] block_offset;
	logic [CNT_W-1:0]  block_pages;

	modport source (output valid, status, block_offset, block_pages, input ready);
	modport sink (input valid, status, block_offset, block_pages, output ready);
endinterface

// ===== hdl/bpa_cfg_if.sv =====
// configuration write channel of the buddy page allocator
interface bpa_cfg_if
	import bpa_pkg::*;
();
	logic             valid;
	logic             ready;
	logic [CNT_W-1:0] reserved_pages;

	modport source (output valid, reserved_pages, input ready);
	modport sink (input valid, reserved_pages, output ready);
endinterface

// ===== hdl/bpa_ram.sv =====
// generic single write port ram with registered read
module bpa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

// ===== hdl/bpa_dp.sv =====
// datapath: node tree memory, walk registers and result registers
module bpa_dp
	import bpa_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  dp_op_t            op,
	output dp_stat_t          stat,
	input  logic [1:0]        in_kind,
	input  logic [CNT_W-1:0]  in_request,
	input  logic [PAGE_W-1:0] in_page,
	input  logic              cfg_valid,
	input  logic [CNT_W-1:0]  cfg_data,
	output logic              cfg_ready,
	output logic [1:0]        out_status,
	output logic [PAGE_W-1:0] out_offset,
	output logic [CNT_W-1:0]  out_pages
);
	logic [NODE_W-1:0] idx_q;
	logic [CNT_W-1:0]  ns_q;
	logic [CNT_W-1:0]  reserved_q;
	logic [CNT_W-1:0]  want_q;
	logic [CNT_W-1:0]  left_q;
	logic              too_big_q;
	kind_t             kind_q;
	logic [PAGE_W-1:0] page_q;
	status_t           res_status_q;
	logic [PAGE_W-1:0] res_off_q;
	logic [CNT_W-1:0]  res_pages_q;

	logic              ram_we;
	logic [NODE_W-1:0] ram_waddr;
	logic [CNT_W-1:0]  ram_wdata;
	logic [NODE_W-1:0] ram_raddr;
	logic [CNT_W-1:0]  ram_rdata;

	kind_t             kind_in;
	logic [CNT_W-1:0]  sel_req;
	logic [CNT_W-1:0]  in_want;
	logic              in_walk;
	logic              in_bad;
	logic [NODE_W-1:0] parent;
	logic [NODE_W-1:0] left_c;
	logic [NODE_W-1:0] right_c;
	logic [NODE_W-1:0] sib_left;
	logic [NODE_W-1:0] leaf;
	logic [NODE_W-1:0] nxt;
	logic              init_last;
	logic              halve;
	logic              go_left;
	logic [CNT_W:0]    pair_sum;
	logic [CNT_W-1:0]  pair_max;
	logic [CNT_W-1:0]  up_val;

	assign kind_in   = kind_t'(in_kind);
	assign sel_req   = (kind_in == KIND_REBUILD) ? reserved_q : in_request;
	assign in_want   = round_pow2(sel_req);
	assign in_walk   = (kind_in == KIND_FREE) || (kind_in == KIND_QUERY);
	assign in_bad    = in_walk && (({1'b0, in_page} >= CNT_W'(TOTAL_PAGES)) ||
		((kind_in == KIND_FREE) && (in_page == '0)));
	assign parent    = (idx_q - NODE_W'(1)) >> 1;
	assign left_c    = NODE_W'({idx_q, 1'b1});
	assign right_c   = left_c + NODE_W'(1);
	assign sib_left  = idx_q[0] ? idx_q : idx_q - NODE_W'(1);
	assign leaf      = NODE_W'(in_page) + NODE_W'(TOTAL_PAGES - 1);
	assign nxt       = idx_q + NODE_W'(1);
	assign init_last = (idx_q == NODE_W'(NODE_COUNT - 1));
	assign halve     = (((nxt + NODE_W'(1)) & nxt) == '0) && !init_last;
	assign go_left   = (ram_rdata >= want_q);
	assign pair_sum  = {1'b0, left_q} + {1'b0, ram_rdata};
	assign pair_max  = (left_q > ram_rdata) ? left_q : ram_rdata;
	assign up_val    = ((kind_q == KIND_FREE) && (pair_sum == {1'b0, ns_q})) ? ns_q : pair_max;
	assign cfg_ready = 1'b1;

	assign stat.in_kind   = kind_in;
	assign stat.in_bad    = in_bad;
	assign stat.no_space  = too_big_q || (ram_rdata < want_q);
	assign stat.want_hit  = (ns_q == want_q);
	assign stat.next_hit  = ((ns_q >> 1) == want_q);
	assign stat.idx_zero  = (idx_q == '0);
	assign stat.node_zero = (ram_rdata == '0);
	assign stat.init_last = init_last;
	assign stat.is_free   = (kind_q == KIND_FREE);

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = idx_q;
		ram_wdata = ns_q;
		ram_raddr = idx_q;
		unique case (op)
			OP_INIT: begin
				ram_we = 1'b1;
			end
			OP_ROOT_RD: begin
				ram_raddr = '0;
			end
			OP_CHILD_RD: begin
				ram_raddr = left_c;
			end
			OP_MARK: begin
				ram_we    = 1'b1;
				ram_wdata = '0;
			end
			OP_RELEASE: begin
				ram_we = 1'b1;
			end
			OP_UP_LEFT: begin
				ram_raddr = sib_left;
			end
			OP_UP_RIGHT: begin
				ram_raddr = right_c;
			end
			OP_UP_WRITE: begin
				ram_we    = 1'b1;
				ram_wdata = up_val;
			end
			default: begin
			end
		endcase
	end

	bpa_ram #(
		.WIDTH(CNT_W),
		.DEPTH(NODE_COUNT)
	) u_tree (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q      <= '0;
			ns_q       <= CNT_W'(TOTAL_PAGES);
			reserved_q <= '0;
		end else begin
			if (cfg_valid) begin
				reserved_q <= cfg_data;
			end
			unique case (op)
				OP_LOAD: begin
					idx_q <= in_walk ? leaf : '0;
					ns_q  <= in_walk ? CNT_W'(1) : CNT_W'(TOTAL_PAGES);
				end
				OP_INIT: begin
					idx_q <= nxt;
					if (halve) begin
						ns_q <= ns_q >> 1;
					end
				end
				OP_ROOT_RD: begin
					idx_q <= '0;
					ns_q  <= CNT_W'(TOTAL_PAGES);
				end
				OP_DESC: begin
					idx_q <= go_left ? left_c : right_c;
					ns_q  <= ns_q >> 1;
				end
				OP_CLIMB, OP_UP_LEFT: begin
					idx_q <= parent;
					ns_q  <= ns_q << 1;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (op)
			OP_LOAD: begin
				kind_q       <= kind_in;
				page_q       <= in_page;
				want_q       <= in_want;
				too_big_q    <= (sel_req > CNT_W'(TOTAL_PAGES));
				res_status_q <= in_bad ? ST_BAD_OFFSET : ST_OK;
				res_off_q    <= '0;
				res_pages_q  <= '0;
			end
			OP_NOSPACE: begin
				res_status_q <= ST_NO_SPACE;
			end
			OP_DESC: begin
				if (!go_left) begin
					res_off_q <= res_off_q + PAGE_W'(ns_q >> 1);
				end
			end
			OP_MARK: begin
				res_pages_q <= ns_q;
			end
			OP_NOTALLOC: begin
				res_status_q <= ST_NOT_ALLOC;
			end
			OP_FOUND: begin
				res_off_q   <= page_q & ~(ns_q[PAGE_W-1:0] - PAGE_W'(1));
				res_pages_q <= ns_q;
			end
			OP_UP_RIGHT: begin
				left_q <= ram_rdata;
			end
			OP_PUBLISH: begin
				out_status <= res_status_q;
				out_offset <= res_off_q;
				out_pages  <= res_pages_q;
			end
			default: begin
			end
		endcase
	end

`ifndef SYNTHESIS
	a_ns_onehot: assert property (@(posedge clk) disable iff (!arst_n) $onehot(ns_q))
		else $error("block size register not a power of two");
`endif
endmodule

// ===== hdl/bpa_ctrl.sv =====
// controller state machine sequencing the tree walks
module bpa_ctrl
	import bpa_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     cmd_valid,
	output logic     cmd_ready,
	output logic     rsp_valid,
	input  logic     rsp_ready,
	input  dp_stat_t stat,
	output dp_op_t   op
);
	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   out_free;

	assign out_free  = !out_valid_q || rsp_ready;
	assign rsp_valid = out_valid_q;
	assign cmd_ready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_CLEAR: begin
				if (stat.init_last) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (cmd_valid) begin
					priority if (stat.in_kind == KIND_ALLOC) state_d = S_A_ROOT;
					else if (stat.in_kind == KIND_REBUILD) state_d = S_INIT;
					else if (stat.in_bad) state_d = S_DONE;
					else state_d = S_F_RD;
				end
			end
			S_INIT: begin
				if (stat.init_last) state_d = S_A_ROOT;
			end
			S_A_ROOT: state_d = S_A_CHK;
			S_A_CHK: begin
				priority if (stat.no_space) state_d = S_DONE;
				else if (stat.want_hit) state_d = S_MARK;
				else state_d = S_A_RD;
			end
			S_A_RD: state_d = S_A_DESC;
			S_A_DESC: state_d = stat.next_hit ? S_MARK : S_A_RD;
			S_MARK: state_d = stat.idx_zero ? S_DONE : S_U_L;
			S_F_RD: state_d = S_F_CHK;
			S_F_CHK: begin
				priority if (stat.node_zero) state_d = stat.is_free ? S_F_WR : S_DONE;
				else if (stat.idx_zero) state_d = S_DONE;
				else state_d = S_F_RD;
			end
			S_F_WR: state_d = stat.idx_zero ? S_DONE : S_U_L;
			S_U_L: state_d = S_U_R;
			S_U_R: state_d = S_U_W;
			S_U_W: state_d = stat.idx_zero ? S_DONE : S_U_L;
			S_DONE: begin
				if (out_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		op = OP_NONE;
		unique case (state_q)
			S_CLEAR, S_INIT: op = OP_INIT;
			S_IDLE: op = cmd_valid ? OP_LOAD : OP_NONE;
			S_A_ROOT: op = OP_ROOT_RD;
			S_A_CHK: op = stat.no_space ? OP_NOSPACE : OP_NONE;
			S_A_RD: op = OP_CHILD_RD;
			S_A_DESC: op = OP_DESC;
			S_MARK: op = OP_MARK;
			S_F_RD: op = OP_NODE_RD;
			S_F_CHK: begin
				priority if (stat.node_zero) op = OP_FOUND;
				else if (stat.idx_zero) op = OP_NOTALLOC;
				else op = OP_CLIMB;
			end
			S_F_WR: op = OP_RELEASE;
			S_U_L: op = OP_UP_LEFT;
			S_U_R: op = OP_UP_RIGHT;
			S_U_W: op = OP_UP_WRITE;
			S_DONE: op = out_free ? OP_PUBLISH : OP_NONE;
			default: op = OP_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (op == OP_PUBLISH) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

`ifndef SYNTHESIS
	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_valid && cmd_ready) |=> (state_q != S_IDLE))
		else $error("transaction accepted but controller stayed idle");
	a_publish_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && out_free) |=> out_valid_q)
		else $error("result finished but not presented");
	a_mark_path: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MARK) |-> ($past(state_q) == S_A_CHK || $past(state_q) == S_A_DESC))
		else $error("block marked used without a descent");
`endif
endmodule

// ===== hdl/buddy_page_allocator.sv =====
// top level of the buddy page allocator
//
//  channel | dir | fields                                   | meaning
//  cmd     | in  | kind, request_pages, page_offset         | allocate, free, query, rebuild
//  rsp     | out | status, block_offset, block_pages        | one result per transaction
//  cfg     | in  | reserved_pages                           | pages reserved by a rebuild
//
// one transaction at a time; each tree level costs a child read and a descent step
// going down (node memory read latency) and two child reads and one write going up;
// a rebuild adds a sweep over all 2047 nodes of the tree memory; after reset the same
// sweep runs before cmd is ready; a held rsp delays only the return to idle, the
// result register parts the two sides
module buddy_page_allocator
	import bpa_pkg::*;
(
	input logic      clk,
	input logic      arst_n,
	bpa_cmd_if.sink  cmd,
	bpa_rsp_if.source rsp,
	bpa_cfg_if.sink  cfg
);
	dp_op_t   op;
	dp_stat_t stat;

	bpa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(cmd.valid),
		.cmd_ready(cmd.ready),
		.rsp_valid(rsp.valid),
		.rsp_ready(rsp.ready),
		.stat     (stat),
		.op       (op)
	);

	bpa_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.op        (op),
		.stat      (stat),
		.in_kind   (cmd.kind),
		.in_request(cmd.request_pages),
		.in_page   (cmd.page_offset),
		.cfg_valid (cfg.valid),
		.cfg_data  (cfg.reserved_pages),
		.cfg_ready (cfg.ready),
		.out_status(rsp.status),
		.out_offset(rsp.block_offset),
		.out_pages (rsp.block_pages)
	);
endmodule

// ===== bench/tb_buddy_page_allocator.sv =====
// testbench for the buddy page allocator: directed and random transactions checked against a tree model
`timescale 1ns / 100ps

module tb_buddy_page_allocator;
	import bpa_pkg::*;

	typedef struct {
		kind_t       kind;
		logic [10:0] request_pages;
		logic [9:0]  page_offset;
	} cmd_item_t;

	typedef struct {
		status_t     status;
		logic [9:0]  block_offset;
		logic [10:0] block_pages;
	} rsp_item_t;

	logic clk;
	logic arst_n;

	bpa_cmd_if cmd ();
	bpa_rsp_if rsp ();
	bpa_cfg_if cfg ();

	buddy_page_allocator DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.rsp    (rsp),
		.cfg    (cfg)
	);

	cmd_item_t   pending_cmds[$];
	rsp_item_t   expected_rsps[$];
	logic [10:0] tree_free[NODE_COUNT];
	logic [10:0] reserve_cfg;
	logic        cmd_taken = 1'b0;
	int          mismatches;
	int          rsp_count;
	int          hold_rsp;
	int          cmd_gap;
	int          rsp_gap;
	int          sent_count;
	int          granted_count;

	initial clk = 1'b0;
	always #10 clk = ~clk;

	function automatic void tree_clear();
		int sz;
		sz = 2 * TOTAL_PAGES;
		for (int i = 0; i < NODE_COUNT; i++) begin
			if (((i + 1) & i) == 0) sz = sz / 2;
			tree_free[i] = 11'(sz);
		end
	endfunction

	function automatic rsp_item_t tree_alloc(input int req);
		rsp_item_t r;
		int want;
		int idx;
		int ns;
		r = '{ST_OK, '0, '0};
		want = (req == 0) ? 1 : req;
		ns = 1;
		while (ns < want) ns = ns * 2;
		want = ns;
		if (want > TOTAL_PAGES || tree_free[0] < want) begin
			r.status = ST_NO_SPACE;
			return r;
		end
		idx = 0;
		for (ns = TOTAL_PAGES; ns != want && ns > 1; ns = ns / 2)
			idx = (tree_free[2 * idx + 1] >= want) ? 2 * idx + 1 : 2 * idx + 2;
		tree_free[idx] = '0;
		r.block_offset = 10'((idx + 1) * ns - TOTAL_PAGES);
		r.block_pages = 11'(ns);
		while (idx != 0) begin
			idx = (idx - 1) / 2;
			tree_free[idx] = (tree_free[2 * idx + 1] > tree_free[2 * idx + 2]) ?
				tree_free[2 * idx + 1] : tree_free[2 * idx + 2];
		end
		return r;
	endfunction

	function automatic rsp_item_t tree_apply(input cmd_item_t c);
		rsp_item_t r;
		int idx;
		int ns;
		int l;
		int rr;
		r = '{ST_OK, '0, '0};
		if (c.kind == KIND_ALLOC) return tree_alloc(c.request_pages);
		if (c.kind == KIND_REBUILD) begin
			tree_clear();
			return tree_alloc(reserve_cfg);
		end
		if (c.kind == KIND_FREE && c.page_offset == 0) begin
			r.status = ST_BAD_OFFSET;
			return r;
		end
		idx = c.page_offset + TOTAL_PAGES - 1;
		ns = 1;
		while (tree_free[idx] != 0) begin
			if (idx == 0) begin
				r.status = ST_NOT_ALLOC;
				return r;
			end
			idx = (idx - 1) / 2;
			ns = ns * 2;
		end
		r.block_offset = 10'((idx + 1) * ns - TOTAL_PAGES);
		r.block_pages = 11'(ns);
		if (c.kind == KIND_FREE) begin
			tree_free[idx] = 11'(ns);
			while (idx != 0) begin
				idx = (idx - 1) / 2;
				ns = ns * 2;
				l = tree_free[2 * idx + 1];
				rr = tree_free[2 * idx + 2];
				tree_free[idx] = (l + rr == ns) ? 11'(ns) : 11'((l > rr) ? l : rr);
			end
		end
		return r;
	endfunction

	// driver
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd.valid <= 1'b0;
			cmd.kind <= '0;
			cmd.request_pages <= '0;
			cmd.page_offset <= '0;
			cmd_gap <= 0;
		end else if (cmd.valid && !cmd_taken) begin
		end else if (cmd_gap > 0) begin
			cmd.valid <= 1'b0;
			cmd_gap <= cmd_gap - 1;
		end else if (pending_cmds.size() > 0) begin
			cmd.valid <= 1'b1;
			cmd.kind <= pending_cmds[0].kind;
			cmd.request_pages <= pending_cmds[0].request_pages;
			cmd.page_offset <= pending_cmds[0].page_offset;
			void'(pending_cmds.pop_front());
			cmd_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 4);
		end else begin
			cmd.valid <= 1'b0;
		end
	end

	// prediction on accepted commands
	always @(posedge clk) begin
		cmd_item_t c;
		cmd_taken = arst_n && cmd.valid && cmd.ready;
		if (cmd_taken) begin
			c.kind = kind_t'(cmd.kind);
			c.request_pages = cmd.request_pages;
			c.page_offset = cmd.page_offset;
			expected_rsps.push_back(tree_apply(c));
			sent_count++;
		end
	end

	// receiver ready
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp.ready <= 1'b0;
			rsp_gap <= 0;
		end else if (hold_rsp > 0) begin
			rsp.ready <= 1'b0;
			hold_rsp <= hold_rsp - 1;
		end else if (rsp_gap > 0) begin
			rsp.ready <= 1'b0;
			rsp_gap <= rsp_gap - 1;
		end else begin
			rsp.ready <= 1'b1;
			rsp_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 4);
		end
	end

	// monitor
	always @(posedge clk) begin
		rsp_item_t e;
		if (arst_n && rsp.valid && rsp.ready) begin
			rsp_count++;
			if (expected_rsps.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected transaction status %0d", rsp.status);
			end else begin
				e = expected_rsps.pop_front();
				if (e.status == ST_OK) granted_count++;
				if (rsp.status !== e.status || rsp.block_offset !== e.block_offset ||
						rsp.block_pages !== e.block_pages) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch %0d: exp %0d/%0d/%0d got %0d/%0d/%0d", rsp_count,
							e.status, e.block_offset, e.block_pages,
							rsp.status, rsp.block_offset, rsp.block_pages);
				end
			end
		end
	end

	task automatic push_cmd(input kind_t k, input int req, input int off);
		cmd_item_t c;
		c.kind = k;
		c.request_pages = 11'(req);
		c.page_offset = 10'(off);
		pending_cmds.push_back(c);
	endtask

	task automatic drain();
		while (pending_cmds.size() > 0 || cmd.valid || expected_rsps.size() > 0)
			@(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	task automatic write_reserve(input int val);
		@(negedge clk);
		cfg.valid <= 1'b1;
		cfg.reserved_pages <= 11'(val);
		@(posedge clk);
		while (!cfg.ready) @(posedge clk);
		reserve_cfg = 11'(val);
		@(negedge clk);
		cfg.valid <= 1'b0;
	endtask

	// allocations, mostly small, with frees and queries at random offsets, plus rare rebuilds
	task automatic random_batch(input int n);
		int r;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(0, 99);
			if (r < 40) begin
				push_cmd(KIND_ALLOC, ($urandom_range(0, 19) == 0) ? $urandom_range(0, 2047) :
					$urandom_range(0, 40), 0);
			end else if (r < 75) begin
				push_cmd(KIND_FREE, $urandom_range(0, 2047), $urandom_range(0, 1023));
			end else if (r < 97) begin
				push_cmd(KIND_QUERY, $urandom_range(0, 2047), $urandom_range(0, 1023));
			end else begin
				push_cmd(KIND_REBUILD, $urandom_range(0, 2047), $urandom_range(0, 1023));
			end
		end
	endtask

	int reserve_set[6] = '{0, 1024, 1, 37, 1025, 2047};

	initial begin
		arst_n = 1'b0;
		cfg.valid = 1'b0;
		cfg.reserved_pages = '0;
		hold_rsp = 0;
		mismatches = 0;
		rsp_count = 0;
		sent_count = 0;
		granted_count = 0;
		reserve_cfg = '0;
		tree_clear();
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed
		push_cmd(KIND_QUERY, 0, 5);
		push_cmd(KIND_FREE, 0, 5);
		push_cmd(KIND_ALLOC, 0, 0);
		push_cmd(KIND_ALLOC, 3, 1023);
		push_cmd(KIND_ALLOC, 1024, 0);
		push_cmd(KIND_ALLOC, 2047, 0);
		push_cmd(KIND_QUERY, 0, 5);
		push_cmd(KIND_FREE, 0, 6);
		push_cmd(KIND_FREE, 0, 0);
		push_cmd(KIND_FREE, 0, 6);
		push_cmd(KIND_REBUILD, 0, 0);
		push_cmd(KIND_QUERY, 0, 0);
		push_cmd(KIND_FREE, 0, 1);
		push_cmd(KIND_ALLOC, 512, 0);
		push_cmd(KIND_ALLOC, 512, 0);
		push_cmd(KIND_QUERY, 0, 1023);
		push_cmd(KIND_FREE, 0, 700);
		push_cmd(KIND_FREE, 0, 700);
		push_cmd(KIND_ALLOC, 1024, 0);
		drain();

		for (int ph = 0; ph < 6; ph++) begin
			write_reserve(reserve_set[ph]);
			push_cmd(KIND_REBUILD, 0, 0);
			random_batch(ph == 2 ? 60 : 200);
			if (ph == 1) begin
				// long receiver stall while commands keep coming
				hold_rsp = 300;
			end
			drain();
		end
		$display("run covered %0d transactions, %0d granted, reserve settings 0 to 2047",
			sent_count, granted_count);
		if (mismatches == 0 && expected_rsps.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		#100ms;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
